@@ sv/nrmc_pkg.sv @@
// ----------------------------------------------------------------------------
// nrmc_pkg
// Shared constants, types and helpers for the RMC sentence checker.
// ----------------------------------------------------------------------------
package nrmc_pkg;

    localparam int LINE_MAX    = 255;
    localparam int POS_W       = $clog2(LINE_MAX + 1);
    localparam int ZONE_W      = 5;
    localparam int HOURS_W     = 5;
    localparam int MINSEC_W    = 7;
    localparam int PREFIX_LEN  = 6;
    localparam int XOR_START   = 4;
    localparam int DIGIT_FIRST = 7;
    localparam int DIGIT_LAST  = 12;
    localparam int NUM_DIGITS  = 6;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int HOURS_DAY   = 24;
    localparam int HEX_RADIX   = 16;

    localparam logic [ZONE_W-1:0] ZONE_RESET = ZONE_W'(8);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;

    // hhmmss as six decimal digits, hour tens first
    typedef logic [3:0] t_digits [NUM_DIGITS];

    typedef struct packed {
        logic [HOURS_W-1:0]  hours;
        logic [MINSEC_W-1:0] minutes;
        logic [MINSEC_W-1:0] seconds;
    } t_clock;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex r;
        r.valid = 1'b1;
        r.value = 4'd0;
        priority if (c >= CH_0 && c <= CH_9) begin
            r.value = 4'(c - CH_0);
        end else if (c >= CH_UA && c <= CH_UF) begin
            r.value = 4'(c - CH_UA + 8'd10);
        end else if (c >= CH_LA && c <= CH_LF) begin
            r.value = 4'(c - CH_LA + 8'd10);
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0:    r = CH_DOLLAR;
            3'd1:    r = CH_G;
            3'd2:    r = CH_P;
            3'd3:    r = CH_R;
            3'd4:    r = CH_M;
            3'd5:    r = CH_C;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

@@ sv/nrmc_time_fmt.sv @@
// ----------------------------------------------------------------------------
// nrmc_time_fmt
// Turns saved hhmmss digits into binary fields, hour shifted by the zone.
// ----------------------------------------------------------------------------
module nrmc_time_fmt
    import nrmc_pkg::*;
(
    input  t_digits            i_digits,
    input  logic [ZONE_W-1:0]  i_zone,
    output t_clock             o_clock
);

    logic [MINSEC_W-1:0] hour_utc;
    logic [7:0]          hour_sum;
    logic [7:0]          hour_a;
    logic [7:0]          hour_b;
    logic [7:0]          hour_c;

    assign hour_utc = MINSEC_W'(i_digits[0]) * MINSEC_W'(10) + MINSEC_W'(i_digits[1]);
    assign hour_sum = 8'(hour_utc) + 8'(i_zone);

    // sum is at most 99 + 31 = 130; three conditional subtracts bring it under 24
    assign hour_a = (hour_sum >= 8'(4 * HOURS_DAY)) ? hour_sum - 8'(4 * HOURS_DAY) : hour_sum;
    assign hour_b = (hour_a >= 8'(2 * HOURS_DAY)) ? hour_a - 8'(2 * HOURS_DAY) : hour_a;
    assign hour_c = (hour_b >= 8'(HOURS_DAY)) ? hour_b - 8'(HOURS_DAY) : hour_b;

    assign o_clock.hours   = hour_c[HOURS_W-1:0];
    assign o_clock.minutes = MINSEC_W'(i_digits[2]) * MINSEC_W'(10) + MINSEC_W'(i_digits[3]);
    assign o_clock.seconds = MINSEC_W'(i_digits[4]) * MINSEC_W'(10) + MINSEC_W'(i_digits[5]);

endmodule

@@ sv/nmea_rmc_check_time_top.sv @@
// ----------------------------------------------------------------------------
// nmea_rmc_check_time_top
// RMC sentence checksum checker with local time capture.
// ----------------------------------------------------------------------------
// Input channel: one line character per transfer (i_ch), i_line_last on the
// final character. Output channel: one result per line, given once its
// last character is processed: pass flag, have-time flag and the latest
// captured time with the hour shifted by the zone offset, modulo 24.
// A character is registered on entry in the input register and processed
// from there; the result of a line is registered in the output register
// when its last character is processed. One character per cycle is taken
// while no line end waits behind a stalled result.
// A stalled result holds the output register; characters that do not end a
// line keep flowing underneath it, and only a second line end waits.
// The user writes the zone offset through i_cfg_we/i_cfg_wdata only while idle; the block does not enforce this.
// Reset (synchronous, i_rst_n low) empties both registers, clears the line
// state and the saved time, and sets the zone offset to 8.
// ----------------------------------------------------------------------------
module nmea_rmc_check_time_top
    import nrmc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [ZONE_W-1:0]   i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_ch,
    input  logic                i_line_last,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_line_ok,
    output logic                o_have_time,
    output logic [HOURS_W-1:0]  o_hours,
    output logic [MINSEC_W-1:0] o_minutes,
    output logic [MINSEC_W-1:0] o_seconds
);

    logic [ZONE_W-1:0] r_zone;

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_last;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_prefix_good, n_prefix_good;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_recent [3];
    logic [7:0]       n_recent [3];
    t_digits          r_line_digits, n_line_digits;
    logic             r_digits_good, n_digits_good;
    t_digits          r_saved, n_saved;
    logic             r_saved_valid, n_saved_valid;

    logic          r_out_valid;
    logic          r_line_ok;
    logic          r_have_time;
    t_clock        r_clock;

    logic             advance;
    logic             step;
    logic             line_ok;
    logic [POS_W-1:0] digit_off;
    t_hex             hex_hi;
    t_hex             hex_lo;
    t_clock           clock_now;

    // only a line end needs the output register free
    assign advance    = !r_in_valid || !r_in_last || !r_out_valid || !i_out_stall;
    assign o_in_stall = !advance;
    assign step       = r_in_valid && advance;

    assign hex_hi    = hex_decode(r_recent[0]);
    assign hex_lo    = hex_decode(r_in_ch);
    assign digit_off = r_pos - POS_W'(DIGIT_FIRST);

    always_comb begin
        n_pos         = r_pos;
        n_prefix_good = r_prefix_good;
        n_xor         = r_xor;
        n_recent      = r_recent;
        n_line_digits = r_line_digits;
        n_digits_good = r_digits_good;
        n_saved       = r_saved;
        n_saved_valid = r_saved_valid;
        line_ok       = 1'b0;
        if (step) begin
            if (r_pos >= POS_W'(LINE_MAX)) begin
                n_prefix_good = 1'b0;
            end else begin
                if (r_pos < POS_W'(PREFIX_LEN) && r_in_ch != prefix_char(r_pos[2:0])) begin
                    n_prefix_good = 1'b0;
                end
                if (r_pos >= POS_W'(DIGIT_FIRST) && r_pos <= POS_W'(DIGIT_LAST)) begin
                    if (r_in_ch >= CH_0 && r_in_ch <= CH_9) begin
                        n_line_digits[digit_off[DIGIT_IDX_W-1:0]] = 4'(r_in_ch - CH_0);
                    end else begin
                        n_digits_good = 1'b0;
                    end
                end
                if (r_pos >= POS_W'(XOR_START)) begin
                    n_xor = r_xor ^ r_recent[2];
                end
                if (r_in_last) begin
                    line_ok = n_prefix_good && r_pos >= POS_W'(PREFIX_LEN - 1)
                              && hex_hi.valid && hex_lo.valid
                              && {hex_hi.value, hex_lo.value} == n_xor;
                    if (line_ok && r_pos >= POS_W'(DIGIT_LAST) && n_digits_good) begin
                        n_saved       = n_line_digits;
                        n_saved_valid = 1'b1;
                    end
                end
                n_recent[2] = r_recent[1];
                n_recent[1] = r_recent[0];
                n_recent[0] = r_in_ch;
                n_pos       = r_pos + POS_W'(1);
            end
            if (r_in_last) begin
                n_pos         = '0;
                n_prefix_good = 1'b1;
                n_xor         = '0;
                n_recent      = '{default: '0};
                n_line_digits = '{default: '0};
                n_digits_good = 1'b1;
            end
        end
    end

    nrmc_time_fmt u_time_fmt (
        .i_digits (n_saved),
        .i_zone   (r_zone),
        .o_clock  (clock_now)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ZONE_RESET;
        end else if (i_cfg_we) begin
            r_zone <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_in_valid) begin
            r_in_ch   <= i_ch;
            r_in_last <= i_line_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_prefix_good <= 1'b1;
            r_xor         <= '0;
            r_recent      <= '{default: '0};
            r_line_digits <= '{default: '0};
            r_digits_good <= 1'b1;
            r_saved       <= '{default: '0};
            r_saved_valid <= 1'b0;
        end else begin
            r_pos         <= n_pos;
            r_prefix_good <= n_prefix_good;
            r_xor         <= n_xor;
            r_recent      <= n_recent;
            r_line_digits <= n_line_digits;
            r_digits_good <= n_digits_good;
            r_saved       <= n_saved;
            r_saved_valid <= n_saved_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_line_ok   <= line_ok;
            r_have_time <= n_saved_valid;
            r_clock     <= clock_now;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_line_ok   = r_line_ok;
    assign o_have_time = r_have_time;
    assign o_hours     = r_clock.hours;
    assign o_minutes   = r_clock.minutes;
    assign o_seconds   = r_clock.seconds;

endmodule

@@ sv/nrmc_checker.sv @@
// ----------------------------------------------------------------------------
// nrmc_checker
// Port-level checks for the RMC sentence checker, bound to the top level.
// ----------------------------------------------------------------------------
module nrmc_checker
    import nrmc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic                o_line_ok,
    input logic                o_have_time,
    input logic [HOURS_W-1:0]  o_hours,
    input logic [MINSEC_W-1:0] o_minutes,
    input logic [MINSEC_W-1:0] o_seconds
);

    logic r_seen_time;

    // once a result has shown a time, every later result must too
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_time <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_have_time) begin
            r_seen_time <= 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_hours < HOURS_W'(HOURS_DAY))
        else $error("hour not wrapped below 24");

    a_time_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_time |-> o_have_time)
        else $error("have_time dropped after a time was captured");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_line_ok)
            && $stable(o_have_time) && $stable(o_hours)
            && $stable(o_minutes) && $stable(o_seconds))
        else $error("stalled result changed");

    // input only backs up behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while result register free");

endmodule

bind nmea_rmc_check_time_top nrmc_checker u_nrmc_checker (.*);
